// ----- hdl/xxtea_pkg.sv -----
// ----------------------------------------------------------------------------
// xxtea_pkg
// Shared types, constants and helpers for the XXTEA block cipher unit.
// ----------------------------------------------------------------------------
`default_nettype none

package xxtea_pkg;

   localparam int WORD_W        = 32;
   localparam int CNT_W         = 7;
   localparam int ROUND_W       = 6;
   localparam int KEY_IDX_W     = 2;
   localparam int KEY_WORDS     = 4;
   localparam int MAX_WORDS_DEF = 64;

   localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;

   typedef struct packed {
      logic              req_type;
      logic [WORD_W-1:0] data_word;
      logic              last_word;
   } xxtea_req_type;

   typedef struct packed {
      logic [WORD_W-1:0] result_word;
      logic              result_last;
      logic              block_error;
   } xxtea_rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PREP,
      ST_RUN,
      ST_EMIT_LD,
      ST_EMIT_WAIT
   } xxtea_state_type;

   // 6 + 52/n for a block of n words
   function automatic logic [ROUND_W-1:0] rounds_for(input logic [CNT_W-1:0] n);
      logic [ROUND_W-1:0] q;
      priority if (n >= 7'd53) q = 6'd0;
      else if (n >= 7'd27)     q = 6'd1;
      else if (n >= 7'd18)     q = 6'd2;
      else if (n >= 7'd14)     q = 6'd3;
      else if (n >= 7'd11)     q = 6'd4;
      else if (n >= 7'd9)      q = 6'd5;
      else if (n == 7'd8)      q = 6'd6;
      else if (n == 7'd7)      q = 6'd7;
      else if (n == 7'd6)      q = 6'd8;
      else if (n == 7'd5)      q = 6'd10;
      else if (n == 7'd4)      q = 6'd13;
      else if (n == 7'd3)      q = 6'd17;
      else                     q = 6'd26;
      return q + 6'd6;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/xxtea_word_ram.sv -----
// ----------------------------------------------------------------------------
// xxtea_word_ram
// Block word store: one write port, one registered read port, write-first
// bypass when both ports hit the same entry.
// ----------------------------------------------------------------------------
`default_nettype none

module xxtea_word_ram
   import xxtea_pkg::*;
#(
   parameter int DEPTH = MAX_WORDS_DEF,
   parameter int AW    = $clog2(MAX_WORDS_DEF)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [WORD_W-1:0] wr_data,
   input  wire logic [AW-1:0]     rd_addr,
   output logic      [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_ff <= wr_data;
      end else begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

`default_nettype wire

// ----- hdl/xxtea_mix.sv -----
// ----------------------------------------------------------------------------
// xxtea_mix
// XXTEA MX mixing function with key word selection.
// ----------------------------------------------------------------------------
`default_nettype none

module xxtea_mix
   import xxtea_pkg::*;
(
   input  wire logic [WORD_W-1:0]    y,
   input  wire logic [WORD_W-1:0]    z,
   input  wire logic [WORD_W-1:0]    sum,
   input  wire logic [KEY_IDX_W-1:0] p_low,
   input  wire logic [WORD_W-1:0]    key [KEY_WORDS],
   output logic      [WORD_W-1:0]    mx
);

   logic [KEY_IDX_W-1:0] e;
   logic [KEY_IDX_W-1:0] kidx;
   logic [WORD_W-1:0]    a;
   logic [WORD_W-1:0]    b;

   always_comb begin
      e    = sum[3:2];
      kidx = p_low ^ e;
      a    = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
      b    = (sum ^ y) + (key[kidx] ^ z);
      mx   = a ^ b;
   end

endmodule

`default_nettype wire

// ----- hdl/xxtea_block_cipher_unit.sv -----
// ----------------------------------------------------------------------------
// xxtea_block_cipher_unit
// XXTEA block encrypt/decrypt over a stored block of 32-bit words.
// ----------------------------------------------------------------------------
// Words of a block are taken one per cycle into a word RAM with one write
// port and one registered read port; the first word's req_type picks encrypt
// or decrypt. After the last word a setup state (ST_PREP) follows, then the
// transform runs one MX update per cycle, bounded by the one read and one
// write the RAM allows per cycle; a block of n words (2 <= n <= MAX_WORDS)
// takes 6 + 52/n rounds of n updates each. The n results then leave one per
// cycle while rsp_ready is held, after a first RAM read in ST_EMIT_LD, with
// result_last on the final word. A one-word block returns unchanged with
// block_error set; a block that ran past MAX_WORDS words has its extra words
// dropped and the rest transformed, with block_error set on every word.
// No new block is taken until the last result transaction of the previous
// one has gone.
// ----------------------------------------------------------------------------
`default_nettype none

module xxtea_block_cipher_unit
   import xxtea_pkg::*;
#(
   parameter int MAX_WORDS = MAX_WORDS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire xxtea_req_type        req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output xxtea_rsp_type             rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [KEY_IDX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]    csr_wdata
);

   localparam int AW = $clog2(MAX_WORDS);
   localparam int CW = $clog2(MAX_WORDS + 1);

   localparam logic [CW-1:0] CNT_MAX = CW'(MAX_WORDS);

   xxtea_state_type    state_ff,     state_in;
   logic [CW-1:0]      count_ff,     count_in;
   logic               ovf_ff,       ovf_in;
   logic               dir_ff,       dir_in;
   logic               out_valid_ff, out_valid_in;

   logic [WORD_W-1:0]  first_ff,     first_in;
   logic [WORD_W-1:0]  last_ff,      last_in;
   logic [CW-1:0]      n_ff,         n_in;
   logic               err_ff,       err_in;
   logic [ROUND_W-1:0] rounds_ff,    rounds_in;
   logic [WORD_W-1:0]  sum_ff,       sum_in;
   logic [AW-1:0]      p_ff,         p_in;
   logic [WORD_W-1:0]  prev_ff,      prev_in;
   logic [WORD_W-1:0]  cur_ff,       cur_in;
   logic [WORD_W-1:0]  wrap_ff,      wrap_in;
   logic [AW-1:0]      idx_ff,       idx_in;
   logic [WORD_W-1:0]  out_word_ff,  out_word_in;
   logic               out_last_ff,  out_last_in;

   logic [WORD_W-1:0]  key_ff [KEY_WORDS];

   logic               ram_we;
   logic [AW-1:0]      ram_wa;
   logic [WORD_W-1:0]  ram_wd;
   logic [AW-1:0]      ram_ra;
   logic [WORD_W-1:0]  ram_rd;

   logic [CW-1:0]      n_dec;
   logic [AW-1:0]      nm1;
   logic [CW-1:0]      n_now;
   logic               is_wrap;
   logic [WORD_W-1:0]  mix_y;
   logic [WORD_W-1:0]  mix_z;
   logic [WORD_W-1:0]  mx;
   logic [WORD_W-1:0]  new_word;
   logic [CNT_W-1:0]   p_ext;
   logic [AW-1:0]      p_next;
   logic [AW-1:0]      idx_inc;

   // key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KEY_WORDS; k++) begin
            key_ff[k] <= '0;
         end
      end else if (csr_we) begin
         key_ff[csr_index] <= csr_wdata;
      end
   end

   xxtea_word_ram #(
      .DEPTH (MAX_WORDS),
      .AW    (AW)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   // round operand selection
   always_comb begin
      n_dec = n_ff - CW'(1);
      nm1   = n_dec[AW-1:0];
      p_ext = CNT_W'(p_ff);
      if (!dir_ff) begin
         is_wrap = (p_ff == nm1);
         mix_y   = is_wrap ? wrap_ff : ram_rd;
         mix_z   = prev_ff;
         p_next  = is_wrap ? '0 : p_ff + AW'(1);
      end else begin
         is_wrap = (p_ff == '0);
         mix_y   = prev_ff;
         mix_z   = is_wrap ? wrap_ff : ram_rd;
         p_next  = is_wrap ? nm1 : p_ff - AW'(1);
      end
   end

   xxtea_mix u_mix (
      .y     (mix_y),
      .z     (mix_z),
      .sum   (sum_ff),
      .p_low (p_ext[KEY_IDX_W-1:0]),
      .key   (key_ff),
      .mx    (mx)
   );

   assign new_word = dir_ff ? (cur_ff - mx) : (cur_ff + mx);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      dir_in       = dir_ff;
      out_valid_in = out_valid_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      n_in         = n_ff;
      err_in       = err_ff;
      rounds_in    = rounds_ff;
      sum_in       = sum_ff;
      p_in         = p_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      wrap_in      = wrap_ff;
      idx_in       = idx_ff;
      out_word_in  = out_word_ff;
      out_last_in  = out_last_ff;
      ram_we       = 1'b0;
      ram_wa       = p_ff;
      ram_wd       = new_word;
      ram_ra       = p_ff;
      req_ready    = 1'b0;
      idx_inc      = idx_ff + AW'(1);
      n_now        = (count_ff < CNT_MAX) ? (count_ff + CW'(1)) : count_ff;

      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (count_ff == '0) begin
                  dir_in   = req_data.req_type;
                  first_in = req_data.data_word;
               end
               if (count_ff < CNT_MAX) begin
                  ram_we   = 1'b1;
                  ram_wa   = count_ff[AW-1:0];
                  ram_wd   = req_data.data_word;
                  last_in  = req_data.data_word;
                  count_in = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.last_word) begin
                  n_in      = n_now;
                  err_in    = (n_now < CW'(2)) || ovf_ff || (count_ff == CNT_MAX);
                  rounds_in = rounds_for(CNT_W'(n_now));
                  count_in  = '0;
                  ovf_in    = 1'b0;
                  idx_in    = '0;
                  ram_ra    = '0;
                  state_in  = (n_now < CW'(2)) ? ST_EMIT_LD : ST_PREP;
               end
            end
         end

         ST_PREP: begin
            if (!dir_ff) begin
               prev_in = last_ff;
               cur_in  = first_ff;
               sum_in  = TEA_DELTA;
               p_in    = '0;
               ram_ra  = AW'(1);
            end else begin
               prev_in = first_ff;
               cur_in  = last_ff;
               sum_in  = WORD_W'(rounds_ff * TEA_DELTA);
               p_in    = nm1;
               ram_ra  = nm1 - AW'(1);
            end
            state_in = ST_RUN;
         end

         ST_RUN: begin
            ram_we  = 1'b1;
            ram_wa  = p_ff;
            ram_wd  = new_word;
            prev_in = new_word;
            cur_in  = is_wrap ? wrap_ff : ram_rd;
            p_in    = p_next;
            if (!dir_ff) begin
               if (p_ff == '0) begin
                  wrap_in = new_word;
               end
               ram_ra = p_next + AW'(1);
            end else begin
               if (p_ff == nm1) begin
                  wrap_in = new_word;
               end
               ram_ra = p_next - AW'(1);
            end
            if (is_wrap) begin
               sum_in    = dir_ff ? (sum_ff - TEA_DELTA) : (sum_ff + TEA_DELTA);
               rounds_in = rounds_ff - ROUND_W'(1);
               if (rounds_ff == ROUND_W'(1)) begin
                  idx_in   = '0;
                  ram_ra   = '0;
                  state_in = ST_EMIT_LD;
               end
            end
         end

         ST_EMIT_LD: begin
            out_valid_in = 1'b1;
            out_word_in  = ram_rd;
            out_last_in  = (idx_ff == nm1);
            ram_ra       = idx_inc;
            state_in     = ST_EMIT_WAIT;
         end

         ST_EMIT_WAIT: begin
            ram_ra = idx_inc;
            if (rsp_ready) begin
               if (idx_ff == nm1) begin
                  out_valid_in = 1'b0;
                  state_in     = ST_LOAD;
               end else begin
                  out_word_in = ram_rd;
                  out_last_in = (idx_inc == nm1);
                  idx_in      = idx_inc;
                  ram_ra      = idx_ff + AW'(2);
               end
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         dir_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         dir_ff       <= dir_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff    <= first_in;
      last_ff     <= last_in;
      n_ff        <= n_in;
      err_ff      <= err_in;
      rounds_ff   <= rounds_in;
      sum_ff      <= sum_in;
      p_ff        <= p_in;
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
      wrap_ff     <= wrap_in;
      idx_ff      <= idx_in;
      out_word_ff <= out_word_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_data.result_word = out_word_ff;
   assign rsp_data.result_last = out_last_ff;
   assign rsp_data.block_error = err_ff;

endmodule

`default_nettype wire
